/* hdl/pfq_pkg.sv */
// Package for the priority FIFO queue: depth, widths, entry type and codes.
// Used by priority_fifo_queue; no dependencies.
package pfq_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned ID_W   = 6;
  localparam int unsigned PRI_W  = 8;
  localparam int unsigned FILL_W = 7;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  id;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_ENQ_SCAN  = 6'b000010,
    S_ENQ_INS   = 6'b000100,
    S_DEQ_HEAD  = 6'b001000,
    S_DEQ_SHIFT = 6'b010000,
    S_FIN       = 6'b100000
  } state_e;

endpackage

/* hdl/priority_fifo_queue.sv */
// Top level of the priority FIFO queue: sequencer around one entry RAM.
// Depends on pfq_pkg and pfq_ram.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: operation_i
//   selects enqueue (proc_id_i, priority_req_i) or dequeue of the head.
//   Output channel (out_valid_o / out_stall_i) returns one result item per
//   input item: status_o, out_id_o, out_priority_o and fill_count_o.
//   Entries are kept sorted in RAM slots, slot 0 the head. Higher priority
//   leaves first; equal priorities leave in arrival order.
// Timing:
//   Enqueue walks from the tail toward the head, one RAM read and one move
//   per cycle, until it meets an entry of equal or higher priority or has
//   moved the head; into an empty queue the entry goes straight to slot 0.
//   Dequeue reads the head and then moves every remaining entry down one
//   slot. Empty and full cases go straight to the result.
//   The single RAM read port sets the pace; in_stall_o is high while busy.
// Reset: queue empty, no result pending. RAM contents are not cleared.
// Stall: a finished result waits in the output register; the next item is
//   accepted meanwhile and its result is held until the output frees up.
module priority_fifo_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [pfq_pkg::ID_W-1:0]    proc_id_i,
  input  logic [pfq_pkg::PRI_W-1:0]   priority_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [pfq_pkg::ID_W-1:0]    out_id_o,
  output logic [pfq_pkg::PRI_W-1:0]   out_priority_o,
  output logic [pfq_pkg::FILL_W-1:0]  fill_count_o
);

  // Sequencer state and working registers.
  pfq_pkg::state_e state_q, state_d;
  logic [pfq_pkg::CNT_W-1:0] count_q, count_d;
  logic [pfq_pkg::IDX_W-1:0] ptr_q, ptr_d;

  // Latched input item.
  logic                      op_q;
  pfq_pkg::entry_t           new_q;

  // Pending result, waiting for the output register.
  pfq_pkg::status_e          res_st_q, res_st_d;
  pfq_pkg::entry_t           res_q, res_d;

  // Output register.
  logic                      out_valid_q;
  logic [1:0]                out_st_q;
  pfq_pkg::entry_t           out_q;
  logic [pfq_pkg::FILL_W-1:0] out_fill_q;

  // RAM port signals.
  logic                          we;
  logic [pfq_pkg::IDX_W-1:0]     waddr;
  pfq_pkg::entry_t               wdata;
  logic [pfq_pkg::IDX_W-1:0]     raddr;
  logic [pfq_pkg::ENTRY_W-1:0]   rdata_raw;
  pfq_pkg::entry_t               rdata;

  logic accept;
  logic out_free;
  logic ptr_is_last;

  assign accept      = in_valid_i && (state_q == pfq_pkg::S_IDLE);
  assign in_stall_o  = (state_q != pfq_pkg::S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign rdata       = pfq_pkg::entry_t'(rdata_raw);
  assign ptr_is_last = ((pfq_pkg::CNT_W'(ptr_q) + pfq_pkg::CNT_W'(1)) == count_q);

  pfq_ram #(
    .WIDTH (pfq_pkg::ENTRY_W),
    .DEPTH (pfq_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (pfq_pkg::ENTRY_W'(wdata)),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    res_st_d = res_st_q;
    res_d    = res_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = new_q;
    raddr    = '0;

    case (state_q)
      pfq_pkg::S_IDLE: begin
        if (accept) begin
          res_st_d = pfq_pkg::ST_OK;
          res_d    = '0;
          if (operation_i == pfq_pkg::OP_DEQ) begin
            // Read the head; an empty queue answers at once.
            raddr = '0;
            if (count_q == '0) begin
              res_st_d = pfq_pkg::ST_EMPTY;
              state_d  = pfq_pkg::S_FIN;
            end else begin
              state_d = pfq_pkg::S_DEQ_HEAD;
            end
          end else if (count_q == pfq_pkg::CNT_W'(pfq_pkg::DEPTH)) begin
            // Drop the entry.
            res_st_d = pfq_pkg::ST_FULL;
            state_d  = pfq_pkg::S_FIN;
          end else if (count_q == '0) begin
            we        = 1'b1;
            waddr     = '0;
            wdata.id  = proc_id_i;
            wdata.pri = priority_req_i;
            count_d   = count_q + pfq_pkg::CNT_W'(1);
            state_d   = pfq_pkg::S_FIN;
          end else begin
            // Start the walk at the tail.
            raddr   = pfq_pkg::IDX_W'(count_q - pfq_pkg::CNT_W'(1));
            ptr_d   = raddr;
            state_d = pfq_pkg::S_ENQ_SCAN;
          end
        end
      end

      pfq_pkg::S_ENQ_SCAN: begin
        // rdata holds slot ptr_q; fetch the next one toward the head.
        raddr = ptr_q - pfq_pkg::IDX_W'(1);
        we    = 1'b1;
        waddr = ptr_q + pfq_pkg::IDX_W'(1);
        if (rdata.pri < new_q.pri) begin
          wdata = rdata;
          if (ptr_q == '0) begin
            state_d = pfq_pkg::S_ENQ_INS;
          end else begin
            ptr_d = ptr_q - pfq_pkg::IDX_W'(1);
          end
        end else begin
          wdata   = new_q;
          count_d = count_q + pfq_pkg::CNT_W'(1);
          state_d = pfq_pkg::S_FIN;
        end
      end

      pfq_pkg::S_ENQ_INS: begin
        // Every held entry moved up: the new one becomes the head.
        we      = 1'b1;
        waddr   = '0;
        wdata   = new_q;
        count_d = count_q + pfq_pkg::CNT_W'(1);
        state_d = pfq_pkg::S_FIN;
      end

      pfq_pkg::S_DEQ_HEAD: begin
        res_d = rdata;
        raddr = pfq_pkg::IDX_W'(1);
        if (count_q == pfq_pkg::CNT_W'(1)) begin
          count_d = '0;
          state_d = pfq_pkg::S_FIN;
        end else begin
          ptr_d   = pfq_pkg::IDX_W'(1);
          state_d = pfq_pkg::S_DEQ_SHIFT;
        end
      end

      pfq_pkg::S_DEQ_SHIFT: begin
        // Move slot ptr_q down by one and fetch the next.
        raddr = ptr_q + pfq_pkg::IDX_W'(1);
        we    = 1'b1;
        waddr = ptr_q - pfq_pkg::IDX_W'(1);
        wdata = rdata;
        if (ptr_is_last) begin
          count_d = count_q - pfq_pkg::CNT_W'(1);
          state_d = pfq_pkg::S_FIN;
        end else begin
          ptr_d = ptr_q + pfq_pkg::IDX_W'(1);
        end
      end

      pfq_pkg::S_FIN: begin
        if (out_free) begin
          state_d = pfq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = pfq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfq_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if ((state_q == pfq_pkg::S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    res_st_q <= res_st_d;
    res_q    <= res_d;
    if (accept) begin
      op_q      <= operation_i;
      new_q.id  <= proc_id_i;
      new_q.pri <= priority_req_i;
    end
    if ((state_q == pfq_pkg::S_FIN) && out_free) begin
      out_st_q   <= res_st_q;
      out_q      <= res_q;
      out_fill_q <= pfq_pkg::FILL_W'(count_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign out_id_o       = out_q.id;
  assign out_priority_o = out_q.pri;
  assign fill_count_o   = out_fill_q;

  // Held entries never exceed the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pfq_pkg::CNT_W'(pfq_pkg::DEPTH))
    else $error("entry count above depth");

  // The tail walk only runs for an enqueue, on a queue that is neither empty nor full.
  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfq_pkg::S_ENQ_SCAN) |->
      (count_q != '0) && (count_q != pfq_pkg::CNT_W'(pfq_pkg::DEPTH)) &&
      (op_q == pfq_pkg::OP_ENQ))
    else $error("enqueue walk on empty or full queue");

  // The shift pass only runs for a dequeue and never moves the head slot.
  a_shift_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfq_pkg::S_DEQ_SHIFT) |-> (ptr_q != '0) && (op_q == pfq_pkg::OP_DEQ))
    else $error("dequeue shift at head slot");

  // A new result only appears when the sequencer finishes an item.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == pfq_pkg::S_FIN))
    else $error("result without finished item");

endmodule

/* hdl/pfq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
